FILE: src/ia64_pkg.sv
// Shared operation codes, pipeline sizing and side-band types for the 64-bit integer ALU.
package ia64_pkg;

	localparam int unsigned DataW = 64;
	localparam int unsigned HalfW = DataW / 2;
	localparam int unsigned ShW   = $clog2(DataW);
	localparam int unsigned OpW   = 4;
	localparam int unsigned DivStages = DataW;

	localparam logic [OpW-1:0] OP_ADD = 4'd0;
	localparam logic [OpW-1:0] OP_SUB = 4'd1;
	localparam logic [OpW-1:0] OP_MUL = 4'd2;
	localparam logic [OpW-1:0] OP_DIV = 4'd3;
	localparam logic [OpW-1:0] OP_MOD = 4'd4;
	localparam logic [OpW-1:0] OP_EQ  = 4'd5;
	localparam logic [OpW-1:0] OP_NE  = 4'd6;
	localparam logic [OpW-1:0] OP_GT  = 4'd7;
	localparam logic [OpW-1:0] OP_LT  = 4'd8;
	localparam logic [OpW-1:0] OP_GE  = 4'd9;
	localparam logic [OpW-1:0] OP_LE  = 4'd10;
	localparam logic [OpW-1:0] OP_SHL = 4'd11;
	localparam logic [OpW-1:0] OP_SHR = 4'd12;
	localparam logic [OpW-1:0] OP_AND = 4'd13;
	localparam logic [OpW-1:0] OP_OR  = 4'd14;
	localparam logic [OpW-1:0] OP_XOR = 4'd15;

	// Side-band word that travels alongside the divider stages.
	typedef struct packed {
		logic [OpW-1:0]   op;
		logic [DataW-1:0] res;
		logic             bzero;
	} side_t;

endpackage

FILE: src/integer_alu_64_core.sv
// Top level of the pipelined 64-bit integer ALU.
//
// One word enters per cycle while the pipeline is not held, and its result leaves
// after one input stage, 64 divider stages and one output register; every
// operation takes the same path so words stay in order. The divider, which
// resolves one quotient bit per stage, sets that depth. The whole pipeline
// holds while the output word is stalled, so the input stall follows the
// output stall only when a finished word is waiting. Divide or modulo by
// zero gives 0 with div_error set; shifts of 64 or more give 0, or sign
// fill for an arithmetic right shift.
module integer_alu_64_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [ia64_pkg::OpW-1:0]    op,
	input  logic [ia64_pkg::DataW-1:0]  operand_a,
	input  logic [ia64_pkg::DataW-1:0]  operand_b,
	input  logic                        signed_shift,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [ia64_pkg::DataW-1:0]  result,
	output logic                        is_boolean,
	output logic                        div_error
);
	import ia64_pkg::*;

	logic adv;
	logic wide_sh;
	logic [ShW-1:0]   sh;
	logic [DataW-1:0] simple_res;

	logic             v_s1;
	logic [OpW-1:0]   op_s1;
	logic [DataW-1:0] a_s1, b_s1, simple_s1;
	logic [DataW-1:0] p_ll_s1, p_lh_s1, p_hl_s1;

	logic             side_v [DivStages];
	side_t            side_s [DivStages];
	side_t            side_in, side_end;
	logic [DataW-1:0] quo, rem;
	logic [HalfW-1:0] cross_lo;

	logic             out_valid_q;
	logic [DataW-1:0] result_q;
	logic             is_boolean_q, div_error_q;

	// Advance everything unless a finished word is held at the output.
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	assign wide_sh = |operand_b[DataW-1:ShW];
	assign sh      = operand_b[ShW-1:0];

	// Combinational operations, worked out before the first register.
	always_comb begin
		case (op)
			OP_ADD:  simple_res = operand_a + operand_b;
			OP_SUB:  simple_res = operand_a - operand_b;
			OP_EQ:   simple_res = DataW'(operand_a == operand_b);
			OP_NE:   simple_res = DataW'(operand_a != operand_b);
			OP_GT:   simple_res = DataW'(operand_a >  operand_b);
			OP_LT:   simple_res = DataW'(operand_a <  operand_b);
			OP_GE:   simple_res = DataW'(operand_a >= operand_b);
			OP_LE:   simple_res = DataW'(operand_a <= operand_b);
			OP_SHL:  simple_res = wide_sh ? '0 : (operand_a << sh);
			OP_SHR: begin
				if (signed_shift)
					simple_res = wide_sh ? {DataW{operand_a[DataW-1]}}
					                     : DataW'($signed(operand_a) >>> sh);
				else
					simple_res = wide_sh ? '0 : (operand_a >> sh);
			end
			OP_AND:  simple_res = operand_a & operand_b;
			OP_OR:   simple_res = operand_a | operand_b;
			OP_XOR:  simple_res = operand_a ^ operand_b;
			default: simple_res = '0;
		endcase
	end

	// Input stage: register operands and the three 32x32 partial products
	// that the low 64 bits of the product need.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1     <= op;
			a_s1      <= operand_a;
			b_s1      <= operand_b;
			simple_s1 <= simple_res;
			p_ll_s1   <= DataW'(operand_a[HalfW-1:0]) * DataW'(operand_b[HalfW-1:0]);
			p_lh_s1   <= DataW'(operand_a[HalfW-1:0]) * DataW'(operand_b[DataW-1:HalfW]);
			p_hl_s1   <= DataW'(operand_a[DataW-1:HalfW]) * DataW'(operand_b[HalfW-1:0]);
		end
	end

	ia64_div u_div (
		.clk       (clk),
		.en        (adv),
		.dividend  (a_s1),
		.divisor   (b_s1),
		.quotient  (quo),
		.remainder (rem)
	);

	// Finish the multiply on entry to the side line; only the low half of the
	// cross terms reaches the result.
	assign cross_lo = HalfW'(p_lh_s1 + p_hl_s1);
	always_comb begin
		side_in.op    = op_s1;
		side_in.bzero = (b_s1 == '0);
		side_in.res   = (op_s1 == OP_MUL) ? p_ll_s1 + {cross_lo, {HalfW{1'b0}}} : simple_s1;
	end

	// Side line matched to the divider depth; valid bits ride along.
	genvar g;
	generate
		for (g = 0; g < DivStages; g++) begin : g_side
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					side_v[g] <= 1'b0;
				end else if (adv) begin
					side_v[g] <= (g == 0) ? v_s1 : side_v[(g == 0) ? 0 : g-1];
				end
			end
			always_ff @(posedge clk) begin
				if (adv)
					side_s[g] <= (g == 0) ? side_in : side_s[(g == 0) ? 0 : g-1];
			end
		end
	endgenerate

	assign side_end = side_s[DivStages-1];

	// Output register: pick the divider result where the op asks for it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= side_v[DivStages-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			is_boolean_q <= (side_end.op inside {[OP_EQ:OP_LE]});
			div_error_q  <= (side_end.op inside {OP_DIV, OP_MOD}) && side_end.bzero;
			case (side_end.op)
				OP_DIV:  result_q <= side_end.bzero ? '0 : quo;
				OP_MOD:  result_q <= side_end.bzero ? '0 : rem;
				default: result_q <= side_end.res;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign result     = result_q;
	assign is_boolean = is_boolean_q;
	assign div_error  = div_error_q;

endmodule

FILE: src/ia64_div.sv
// Fully pipelined unsigned restoring divider, one quotient bit per stage.
module ia64_div (
	input  logic                      clk,
	input  logic                      en,
	input  logic [ia64_pkg::DataW-1:0] dividend,
	input  logic [ia64_pkg::DataW-1:0] divisor,
	output logic [ia64_pkg::DataW-1:0] quotient,
	output logic [ia64_pkg::DataW-1:0] remainder
);
	import ia64_pkg::*;

	logic [DataW-1:0] rem_s [DivStages];
	logic [DataW-1:0] quo_s [DivStages];
	logic [DataW-1:0] dvs_s [DivStages];

	genvar g;
	generate
		for (g = 0; g < DivStages; g++) begin : g_stage
			logic [DataW-1:0] rem_in, quo_in, dvs_in;
			logic [DataW:0]   trial;
			logic             fits;
			if (g == 0) begin : g_first
				assign rem_in = '0;
				assign quo_in = dividend;
				assign dvs_in = divisor;
			end else begin : g_next
				assign rem_in = rem_s[g-1];
				assign quo_in = quo_s[g-1];
				assign dvs_in = dvs_s[g-1];
			end
			// Shift the next dividend bit into the partial remainder and try the subtract.
			assign trial = {rem_in, quo_in[DataW-1]};
			assign fits  = trial >= {1'b0, dvs_in};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[g] <= fits ? DataW'(trial - {1'b0, dvs_in}) : trial[DataW-1:0];
					quo_s[g] <= {quo_in[DataW-2:0], fits};
					dvs_s[g] <= dvs_in;
				end
			end
		end
	endgenerate

	assign quotient  = quo_s[DivStages-1];
	assign remainder = rem_s[DivStages-1];

endmodule
